[design/bfa_pkg.sv]
// Shared types and constants for the best-fit block allocator.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam int SLOT_W = 4;
    localparam int SIZE_W = 16;
    localparam int CFG_W  = 5;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

    typedef struct packed {
        logic valid;
        logic found;
    } t_tok_ctl;

endpackage

[design/bfa_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on bfa_pkg for the field widths.
`timescale 1ns / 1ps

interface bfa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [bfa_pkg::SLOT_W-1:0] block_slot;
    logic [bfa_pkg::SIZE_W-1:0] size_value;

    modport source (output valid, req_type, block_slot, size_value, input ready);
    modport sink   (input valid, req_type, block_slot, size_value, output ready);
endinterface

interface bfa_res_if;
    logic                       valid;
    logic                       ready;
    logic                       granted;
    logic [bfa_pkg::SLOT_W-1:0] chosen_block;
    logic [bfa_pkg::SIZE_W-1:0] size_left;

    modport source (output valid, granted, chosen_block, size_left, input ready);
    modport sink   (input valid, granted, chosen_block, size_left, output ready);
endinterface

[design/best_fit_block_allocator.sv]
// Best-fit block allocator: accepts load and allocate words on i_req and
// returns one result word per allocate on o_res. Takes a single 5-bit
// configuration register (active_blocks) through i_cfg_we / i_cfg_wdata.
// A load word is taken while idle and writes its entry at once; it gives
// no result. An allocate word is injected into a chain of NUM_BLOCKS cells,
// each holding one free size; the best-fit word moves one cell per cycle.
// The result word appears once the allocate has passed the chain and
// been captured and written back; i_req.ready is low for that time, so
// no new word is taken while an allocate is in flight. The wait is set
// by the chain length plus a capture step and a write-back step.
// The output register lets a load be accepted while a result waits; a
// stalled receiver holds o_res and delays the write-back of the next
// allocate until the register frees.
// Synchronous active-low reset clears every entry to zero, sets
// active_blocks to 16 and drops o_res.valid.
// Depends on bfa_pkg, bfa_if and bfa_cell.
`timescale 1ns / 1ps

module best_fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0] i_cfg_wdata,
    bfa_req_if.sink                   i_req,
    bfa_res_if.source                 o_res
);

    localparam int IW = $clog2(NUM_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [bfa_pkg::CFG_W-1:0] r_active;
    logic                      r_res_found;
    logic [IW-1:0]             r_res_idx;
    logic [SIZE_BITS-1:0]      r_res_val;
    logic [SIZE_BITS-1:0]      r_res_req;
    logic                      r_ovalid;
    logic                      r_ogranted;
    logic [bfa_pkg::SLOT_W-1:0] r_ochosen;
    logic [bfa_pkg::SIZE_W-1:0] r_oleft;

    bfa_pkg::t_tok_ctl    tok_ctl [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] tok_req [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] tok_val [0:NUM_BLOCKS];
    logic [IW-1:0]        tok_idx [0:NUM_BLOCKS];

    logic                 in_acc;
    logic                 out_free;
    logic                 wb_go;
    logic [31:0]          size32;
    logic [31:0]          slot32;
    logic [SIZE_BITS-1:0] req_size;
    logic                 load_ok;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic [SIZE_BITS-1:0] wr_val;
    logic [SIZE_BITS-1:0] n_left;
    logic [31:0]          left32;
    logic [31:0]          idx32;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_res.ready;
    assign wb_go       = (r_state == S_DONE) && out_free;

    assign size32   = 32'(i_req.size_value);
    assign req_size = size32[SIZE_BITS-1:0];
    assign slot32   = 32'(i_req.block_slot);
    assign load_ok  = in_acc && (i_req.req_type == bfa_pkg::REQ_LOAD)
                      && (slot32 < 32'(NUM_BLOCKS));

    assign n_left = r_res_val - r_res_req;
    assign left32 = 32'(n_left);
    assign idx32  = 32'(r_res_idx);

    assign wr_en  = load_ok || (wb_go && r_res_found);
    assign wr_idx = load_ok ? slot32[IW-1:0] : r_res_idx;
    assign wr_val = load_ok ? req_size : n_left;

    assign tok_ctl[0].valid = in_acc && (i_req.req_type == bfa_pkg::REQ_ALLOC);
    assign tok_ctl[0].found = 1'b0;
    assign tok_req[0]       = req_size;
    assign tok_val[0]       = '0;
    assign tok_idx[0]       = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        bfa_cell #(
            .IDX       (g),
            .IW        (IW),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_active   (r_active),
            .i_wr_en    (wr_en),
            .i_wr_idx   (wr_idx),
            .i_wr_val   (wr_val),
            .i_ctl      (tok_ctl[g]),
            .i_req      (tok_req[g]),
            .i_best_val (tok_val[g]),
            .i_best_idx (tok_idx[g]),
            .o_ctl      (tok_ctl[g+1]),
            .o_req      (tok_req[g+1]),
            .o_best_val (tok_val[g+1]),
            .o_best_idx (tok_idx[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= bfa_pkg::ACTIVE_RST;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tok_ctl[0].valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok_ctl[NUM_BLOCKS].valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (r_state == S_SCAN) begin
            r_res_found <= tok_ctl[NUM_BLOCKS].found;
            r_res_idx   <= tok_idx[NUM_BLOCKS];
            r_res_val   <= tok_val[NUM_BLOCKS];
            r_res_req   <= tok_req[NUM_BLOCKS];
        end
        if (wb_go) begin
            r_ogranted <= r_res_found;
            r_ochosen  <= r_res_found ? idx32[bfa_pkg::SLOT_W-1:0] : '0;
            r_oleft    <= r_res_found ? left32[bfa_pkg::SIZE_W-1:0] : '0;
        end
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.granted      = r_ogranted;
    assign o_res.chosen_block = r_ochosen;
    assign o_res.size_left    = r_oleft;

endmodule

[design/bfa_cell.sv]
// One cell of the search chain: holds one free-size entry and passes the
// running best-fit word to its neighbour every cycle. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_cell #(
    parameter int IDX       = 0,
    parameter int IW        = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [bfa_pkg::CFG_W-1:0] i_active,
    input  logic                      i_wr_en,
    input  logic [IW-1:0]             i_wr_idx,
    input  logic [SIZE_BITS-1:0]      i_wr_val,
    input  bfa_pkg::t_tok_ctl         i_ctl,
    input  logic [SIZE_BITS-1:0]      i_req,
    input  logic [SIZE_BITS-1:0]      i_best_val,
    input  logic [IW-1:0]             i_best_idx,
    output bfa_pkg::t_tok_ctl         o_ctl,
    output logic [SIZE_BITS-1:0]      o_req,
    output logic [SIZE_BITS-1:0]      o_best_val,
    output logic [IW-1:0]             o_best_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [8:0]    CMP_IDX = 9'(IDX);

    logic [SIZE_BITS-1:0] r_val;
    bfa_pkg::t_tok_ctl    r_ctl;
    logic [SIZE_BITS-1:0] r_req;
    logic [SIZE_BITS-1:0] r_best_val;
    logic [IW-1:0]        r_best_idx;
    logic                 in_range;
    logic                 take;

    assign in_range = ({4'b0, i_active} > CMP_IDX);
    assign take     = i_ctl.valid && in_range && (r_val >= i_req)
                      && (!i_ctl.found || (r_val < i_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_ctl <= '0;
        end else begin
            if (i_wr_en && (i_wr_idx == MY_IDX)) begin
                r_val <= i_wr_val;
            end
            r_ctl.valid <= i_ctl.valid;
            r_ctl.found <= i_ctl.found || take;
        end
        r_req      <= i_req;
        r_best_val <= take ? r_val : i_best_val;
        r_best_idx <= take ? MY_IDX : i_best_idx;
    end

    assign o_ctl      = r_ctl;
    assign o_req      = r_req;
    assign o_best_val = r_best_val;
    assign o_best_idx = r_best_idx;

endmodule

[design/bfa_chk.sv]
// Port-level checker for the best-fit block allocator, bound to the top.
// Depends on bfa_pkg for field widths.
`timescale 1ns / 1ps

module bfa_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_req_type,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic                       i_granted,
    input logic [bfa_pkg::SLOT_W-1:0] i_chosen,
    input logic [bfa_pkg::SIZE_W-1:0] i_left
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result word valid after reset");

    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_type == bfa_pkg::REQ_ALLOC))
        |=> !i_req_ready)
        else $error("request taken during a search");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_granted) |-> ((i_chosen == '0) && (i_left == '0)))
        else $error("refused word carries nonzero fields");

    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_req_ready))
        else $error("result word without a preceding search");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
        (i_res_valid && $stable(i_granted) && $stable(i_chosen) && $stable(i_left)))
        else $error("stalled result word changed");

endmodule

bind best_fit_block_allocator bfa_chk u_bfa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_granted   (o_res.granted),
    .i_chosen    (o_res.chosen_block),
    .i_left      (o_res.size_left)
);

[bench/tb_best_fit_block_allocator.sv]
// Self-checking bench for best_fit_block_allocator: load and allocate words
// go in under random bursts and stalls, and every grant is checked against a
// local best-fit table. Depends on bfa_pkg, bfa_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;

    localparam int NUM_BLOCKS = 16;
    localparam int SETTLE_CYC = NUM_BLOCKS + 8;
    localparam int SLOT_W     = bfa_pkg::SLOT_W;
    localparam int SIZE_W     = bfa_pkg::SIZE_W;
    localparam int CFG_W      = bfa_pkg::CFG_W;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] chosen;
        logic [SIZE_W-1:0] left;
    } t_grant;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    bfa_req_if req_ch ();
    bfa_res_if res_ch ();

    best_fit_block_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    logic [SIZE_W-1:0] free_size [NUM_BLOCKS];
    logic [CFG_W-1:0]  active_cnt;
    t_grant            grant_q[$];
    int                mismatch_cnt;
    bit                quiet_tx;
    bit                quiet_rx;
    bit                long_hold;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    // best fit over the active entries, lowest index on a tie; charges the table
    function automatic t_grant fit_request(input logic [SIZE_W-1:0] req_sz);
        t_grant g;
        int     span;
        int     pick;
        logic   hit;
        g    = '0;
        hit  = 1'b0;
        pick = 0;
        span = (active_cnt > NUM_BLOCKS) ? NUM_BLOCKS : int'(active_cnt);
        for (int j = 0; j < span; j++) begin
            if (free_size[j] >= req_sz && (!hit || free_size[j] < free_size[pick])) begin
                pick = j;
                hit  = 1'b1;
            end
        end
        if (hit) begin
            free_size[pick] = free_size[pick] - req_sz;
            g.granted       = 1'b1;
            g.chosen        = pick[SLOT_W-1:0];
            g.left          = free_size[pick];
        end
        return g;
    endfunction

    // hold valid high until the word is taken; valid stays up for a following word
    task automatic send_word(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [SIZE_W-1:0] sz);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.block_slot <= slot;
        req_ch.size_value <= sz;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (kind == bfa_pkg::REQ_LOAD) begin
            free_size[slot] = sz;
        end else begin
            grant_q.push_back(fit_request(sz));
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_active(input logic [CFG_W-1:0] v);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        active_cnt = v;
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return SIZE_W'($urandom);
            1:       return '0;
            2:       return '1;
            3:       return SIZE_W'($urandom_range(1, 20));
            default: return SIZE_W'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic run_random(input int n_words, input int alloc_pct);
        int   sent;
        int   burst;
        logic kind;
        sent = 0;
        while (sent < n_words) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n_words; k++) begin
                kind = ($urandom_range(0, 99) < alloc_pct) ? bfa_pkg::REQ_ALLOC
                                                           : bfa_pkg::REQ_LOAD;
                send_word(kind, SLOT_W'($urandom_range(0, NUM_BLOCKS - 1)), pick_size());
                sent++;
            end
            if (!quiet_tx) idle_cycles($urandom_range(0, 10));
        end
    endtask

    task automatic test_reset_contents();
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
        send_word(bfa_pkg::REQ_ALLOC, 4'd15, 16'hFFFF);
    endtask

    task automatic test_best_fit_ties();
        send_word(bfa_pkg::REQ_LOAD, 4'd0, 16'hFFFF);
        send_word(bfa_pkg::REQ_LOAD, 4'd15, 16'd1);
        send_word(bfa_pkg::REQ_LOAD, 4'd7, 16'd100);
        send_word(bfa_pkg::REQ_LOAD, 4'd3, 16'd100);
        send_word(bfa_pkg::REQ_LOAD, 4'd9, 16'h5555);
        send_word(bfa_pkg::REQ_LOAD, 4'd10, 16'hAAAA);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd100);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd100);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'h5555);
    endtask

    task automatic test_active_extremes();
        set_active(5'd0);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        set_active(5'd1);
        send_word(bfa_pkg::REQ_LOAD, 4'd12, 16'd500);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd10);
        set_active(5'd31);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd10);
        set_active(5'd17);
        send_word(bfa_pkg::REQ_ALLOC, 4'd0, 16'd0);
        set_active(bfa_pkg::ACTIVE_RST);
    endtask

    task automatic test_random_full();
        run_random(600, 40);
    endtask

    task automatic test_random_narrow();
        set_active(CFG_W'($urandom_range(2, 15)));
        run_random(150, 40);
        set_active(CFG_W'($urandom_range(2, 15)));
        run_random(150, 40);
    endtask

    task automatic test_random_single();
        set_active(5'd1);
        run_random(150, 40);
    endtask

    task automatic test_random_none();
        set_active(5'd0);
        run_random(80, 50);
    endtask

    task automatic test_random_oversize();
        set_active(5'd31);
        run_random(80, 40);
        set_active(5'd17);
        run_random(70, 40);
        set_active(bfa_pkg::ACTIVE_RST);
    endtask

    task automatic test_backpressure();
        long_hold = 1'b1;
        run_random(120, 70);
        wait_drain();
    endtask

    task automatic test_streaming();
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        run_random(300, 45);
        wait_drain();
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (quiet_rx) begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_grant
        t_grant want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = grant_q.pop_front();
                if (res_ch.granted !== want.granted)
                    report_mismatch($sformatf("granted %0b, want %0b",
                                              res_ch.granted, want.granted));
                if (res_ch.chosen_block !== want.chosen)
                    report_mismatch($sformatf("chosen_block %0d, want %0d",
                                              res_ch.chosen_block, want.chosen));
                if (res_ch.size_left !== want.left)
                    report_mismatch($sformatf("size_left %0d, want %0d",
                                              res_ch.size_left, want.left));
            end
        end
    end

    initial begin
        mismatch_cnt = 0;
        quiet_tx     = 1'b0;
        quiet_rx     = 1'b0;
        long_hold    = 1'b0;
        active_cnt   = bfa_pkg::ACTIVE_RST;
        for (int j = 0; j < NUM_BLOCKS; j++) free_size[j] = '0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= bfa_pkg::REQ_LOAD;
        req_ch.block_slot <= '0;
        req_ch.size_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_contents();
        test_best_fit_ties();
        test_active_extremes();
        test_random_full();
        test_backpressure();
        test_random_narrow();
        test_random_single();
        test_random_none();
        test_random_oversize();
        test_streaming();

        wait_drain();
        if (mismatch_cnt == 0 && grant_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/bfa_pkg.sv
design/bfa_if.sv
design/bfa_cell.sv
design/best_fit_block_allocator.sv
design/bfa_chk.sv
bench/tb_best_fit_block_allocator.sv
